@@ sv/tas_pkg.sv @@
// Shared types and constants for the threshold alarm set.
package tas_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY  = 2'd1;

	localparam int CFG_DATA_W = 16;
	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	// Operation codes carried by an input item
	typedef enum logic [1:0] {
		OP_EVENT  = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [15:0]        sensor_id;
		logic               is_temperature;
		logic signed [15:0] reading;
	} in_item_t;

	typedef struct packed {
		logic       was_present;
		logic       success;
		logic       alarm_on;
		logic       alarm_off;
		logic       set_full;
		logic [4:0] active_count;
	} out_item_t;

endpackage

@@ sv/threshold_alarm_set_core.sv @@
// Threshold alarm set: a bounded set of active sensor ids kept in a chain of
// table cells. An accepted item's id walks down the chain one cell per cycle;
// each cell compares it with its entry and the token also picks up the last
// entry, needed to fill the hole on a delete. After the walk a decision step
// decides the operation, writes one slot and loads the result register once
// the output register is free. The input is stalled from acceptance until the
// result is loaded, so a new item is not taken before the last one is through.
// A finished result waits in the output register while the next item is taken.
// Configuration writes are accepted at any time and must only be issued while
// the block is idle.
module threshold_alarm_set_core #(
	parameter int TABLE_DEPTH = 16,
	parameter int ID_WIDTH    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  tas_pkg::in_item_t                    in_item,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output tas_pkg::out_item_t                   out_item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tas_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [tas_pkg::CFG_DATA_W-1:0]       cfg_data
);

	import tas_pkg::*;

	localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	logic               in_fire;
	logic [31:0]        id_ext;
	logic [ID_WIDTH-1:0] key_in;

	// configuration registers
	logic signed [15:0] thr_q;
	logic [4:0]         cap_q;
	logic [31:0]        cap_ext;
	logic [31:0]        cap_eff;

	// item held during the walk
	op_t                 op_q;
	logic                temp_q;
	logic                gt_q;
	logic [ID_WIDTH-1:0] key_q;

	// walk result
	logic                hit_q;
	logic [SW-1:0]       slot_q;
	logic [ID_WIDTH-1:0] last_q;

	logic [CW-1:0] count_q, count_d;
	logic [31:0]   cnt_ext;

	// decision
	logic can_ins, do_ins, do_del, ok, on, off, full;
	logic out_load;
	logic                wr_en;
	logic [SW-1:0]       wr_slot;
	logic [ID_WIDTH-1:0] wr_data;

	logic      out_valid_q;
	out_item_t out_item_q;

	// cell chain wiring
	logic                vld_c  [0:TABLE_DEPTH];
	logic [ID_WIDTH-1:0] key_c  [0:TABLE_DEPTH];
	logic                hit_c  [0:TABLE_DEPTH];
	logic [SW-1:0]       slot_c [0:TABLE_DEPTH];
	logic [ID_WIDTH-1:0] last_c [0:TABLE_DEPTH];

	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Keep the low ID_WIDTH bits of the id
	assign id_ext = 32'(in_item.sensor_id);
	assign key_in = id_ext[ID_WIDTH-1:0];

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			cap_q <= CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q <= $signed(cfg_data);
				REG_CAPACITY:  cap_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Usable capacity: zero counts as one, saturate at the table depth
	assign cap_ext = 32'(cap_q);
	always_comb begin
		if (cap_ext == 32'd0) begin
			cap_eff = 32'd1;
		end else if (cap_ext > 32'(TABLE_DEPTH)) begin
			cap_eff = 32'(TABLE_DEPTH);
		end else begin
			cap_eff = cap_ext;
		end
	end

	// Inject the search token at the head of the chain
	assign vld_c[0]  = in_fire;
	assign key_c[0]  = key_in;
	assign hit_c[0]  = 1'b0;
	assign slot_c[0] = '0;
	assign last_c[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		tas_cell #(
			.IDX      (i),
			.ID_WIDTH (ID_WIDTH),
			.SW       (SW),
			.CW       (CW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_i   (vld_c[i]),
			.key_i   (key_c[i]),
			.hit_i   (hit_c[i]),
			.slot_i  (slot_c[i]),
			.last_i  (last_c[i]),
			.vld_o   (vld_c[i+1]),
			.key_o   (key_c[i+1]),
			.hit_o   (hit_c[i+1]),
			.slot_o  (slot_c[i+1]),
			.last_o  (last_c[i+1]),
			.count   (count_q),
			.wr_en   (wr_en),
			.wr_slot (wr_slot),
			.wr_data (wr_data)
		);
	end

	// Hold the item fields for the decision step
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= op_t'(in_item.operation);
			temp_q <= in_item.is_temperature;
			gt_q   <= in_item.reading > thr_q;
			key_q  <= key_in;
		end
	end

	// Capture the token at the end of the chain
	always_ff @(posedge clk) begin
		if (vld_c[TABLE_DEPTH]) begin
			hit_q  <= hit_c[TABLE_DEPTH];
			slot_q <= slot_c[TABLE_DEPTH];
			last_q <= last_c[TABLE_DEPTH];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_SCAN;
			S_SCAN: if (vld_c[TABLE_DEPTH]) state_d = S_DONE;
			S_DONE: if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: in_stall = 1'b0;
			S_SCAN: ;
			S_DONE: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	// Decide the operation from the walk result
	assign can_ins = 32'(count_q) < cap_eff;

	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		ok     = 1'b0;
		on     = 1'b0;
		off    = 1'b0;
		full   = 1'b0;
		unique case (op_q)
			OP_EVENT: begin
				ok = 1'b1;
				if (temp_q) begin
					if (gt_q) begin
						if (!hit_q) begin
							do_ins = can_ins;
							on     = can_ins;
							full   = !can_ins;
						end
					end else if (hit_q) begin
						do_del = 1'b1;
						off    = 1'b1;
					end
				end
			end
			OP_ADD: begin
				if (hit_q) begin
					ok = 1'b1;
				end else begin
					do_ins = can_ins;
					ok     = can_ins;
					full   = !can_ins;
				end
			end
			OP_REMOVE: begin
				do_del = hit_q;
				ok     = hit_q;
			end
			OP_QUERY: ok = hit_q;
			default: ;
		endcase
	end

	// Insert at the fill count, or move the last entry into the freed slot
	assign wr_en   = out_load && (do_ins || do_del);
	assign wr_slot = do_ins ? count_q[SW-1:0] : slot_q;
	assign wr_data = do_ins ? key_q : last_q;

	always_comb begin
		if (do_ins) begin
			count_d = count_q + CW'(1);
		end else if (do_del) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (out_load) begin
			count_q <= count_d;
		end
	end

	assign cnt_ext = 32'(count_d);

	// Output register: load a result, drop it once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q.was_present  <= hit_q;
			out_item_q.success      <= ok;
			out_item_q.alarm_on     <= on;
			out_item_q.alarm_off    <= off;
			out_item_q.set_full     <= full;
			out_item_q.active_count <= cnt_ext[4:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

@@ sv/tas_cell.sv @@
// One slot of the id table: holds an entry and passes the search key to its neighbor.
module tas_cell #(
	parameter int IDX      = 0,
	parameter int ID_WIDTH = 16,
	parameter int SW       = 4,
	parameter int CW       = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	// search token from the previous cell
	input  logic                vld_i,
	input  logic [ID_WIDTH-1:0] key_i,
	input  logic                hit_i,
	input  logic [SW-1:0]       slot_i,
	input  logic [ID_WIDTH-1:0] last_i,
	// search token to the next cell
	output logic                vld_o,
	output logic [ID_WIDTH-1:0] key_o,
	output logic                hit_o,
	output logic [SW-1:0]       slot_o,
	output logic [ID_WIDTH-1:0] last_o,
	// table state and write broadcast
	input  logic [CW-1:0]       count,
	input  logic                wr_en,
	input  logic [SW-1:0]       wr_slot,
	input  logic [ID_WIDTH-1:0] wr_data
);

	logic [ID_WIDTH-1:0] entry_q;
	logic                live;
	logic                is_last;
	logic                match;

	// Only slots below the fill count hold entries
	assign live    = CW'(IDX) < count;
	assign is_last = CW'(IDX + 1) == count;
	assign match   = vld_i && live && !hit_i && (entry_q == key_i);

	// Advance the token one cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	// Carry key, hit slot and the last entry along with the token
	always_ff @(posedge clk) begin
		key_o  <= key_i;
		hit_o  <= hit_i || match;
		slot_o <= match ? SW'(IDX) : slot_i;
		last_o <= is_last ? entry_q : last_i;
	end

	// Take a broadcast write addressed to this slot
	always_ff @(posedge clk) begin
		if (wr_en && (wr_slot == SW'(IDX))) begin
			entry_q <= wr_data;
		end
	end

endmodule

@@ sv/tas_checker.sv @@
// Port-level checks for the threshold alarm set, bound to the top level.
module tas_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input tas_pkg::out_item_t               out_item
);

	import tas_pkg::*;

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// One item at a time: an accepted transaction stalls the input next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	// Alarm flags exclude each other and a refused insert
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.alarm_on && out_item.alarm_off)
			&& !(out_item.alarm_on && out_item.set_full))
		else $error("conflicting alarm flags");

	// A refused insert means the id was absent
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.set_full |-> !out_item.was_present)
		else $error("set_full with presence");

	// Alarm changes agree with prior presence
	a_presence: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.alarm_on && out_item.was_present)
			&& !(out_item.alarm_off && !out_item.was_present))
		else $error("alarm change disagrees with presence");

endmodule

bind threshold_alarm_set_core tas_checker u_tas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
